FILE: hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helper functions of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [3:0] ERR_UNEXPECTED   = 4'd0;
   localparam logic [3:0] ERR_CUT_ESCAPE   = 4'd1;
   localparam logic [3:0] ERR_SHORT_HEX    = 4'd2;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
   localparam logic [3:0] ERR_NO_LOW       = 4'd4;
   localparam logic [3:0] ERR_BAD_LOW      = 4'd5;
   localparam logic [3:0] ERR_STRAY_LOW    = 4'd6;
   localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd7;
   localparam logic [3:0] ERR_RAW_CONTROL  = 4'd8;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

   // characters
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_U         = 8'h75;

   // surrogate prefixes (top six bits of a 16-bit unit)
   localparam logic [5:0] SURR_HIGH = 6'b110110;
   localparam logic [5:0] SURR_LOW  = 6'b110111;

   localparam int QUEUE_DEPTH_DEF = 4;

   // widths of the result words out of the block and the text words into it
   localparam int RSP_DATA_W = 16;
   localparam int REQ_DATA_W = 8;

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_STR     = 8'b0000_0010,
      PH_ESC     = 8'b0000_0100,
      PH_HEX     = 8'b0000_1000,
      PH_WANT_BS = 8'b0001_0000,
      PH_WANT_U  = 8'b0010_0000,
      PH_LOW_HEX = 8'b0100_0000,
      PH_DEAD    = 8'b1000_0000
   } phase_type;

   // all results caused by one input byte: content bytes first, then an
   // optional completion or error word
   typedef struct packed {
      logic [2:0]  nbytes;
      logic [31:0] data;      // first byte in the low bits
      logic        tail_en;
      logic [1:0]  tail_kind;
      logic [3:0]  tail_code;
   } burst_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic [2:0]  nbytes;
      logic [31:0] data;
   } utf8_type;

   function automatic hex_type hex_value(input logic [7:0] b);
      hex_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.val = 4'(b - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // simple escape letter to its byte; ok low for anything else
   function automatic hex_type escape_map(input logic [7:0] b, output logic [7:0] c);
      hex_type r;
      r = '0;
      r.ok = 1'b1;
      case (b)
         8'h22:   c = 8'h22;
         8'h5C:   c = 8'h5C;
         8'h2F:   c = 8'h2F;
         8'h62:   c = 8'h08;
         8'h66:   c = 8'h0C;
         8'h6E:   c = 8'h0A;
         8'h72:   c = 8'h0D;
         8'h74:   c = 8'h09;
         default: begin
            c    = 8'h00;
            r.ok = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7F) begin
         r.nbytes = 3'd1;
         r.data   = {24'd0, cp[7:0]};
      end else if (cp <= 21'h7FF) begin
         r.nbytes = 3'd2;
         r.data   = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      end else if (cp <= 21'hFFFF) begin
         r.nbytes = 3'd3;
         r.data   = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      end else begin
         r.nbytes = 3'd4;
         r.data   = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                     5'b11110, cp[20:18]};
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// scan state machine: classifies each text byte and builds its result burst
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       queue_full,
   output logic       push,
   output burst_type  burst
);

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  hi_ff, hi_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        bad_ff, bad_in;

   hex_type     hv;
   hex_type     ev;
   logic [7:0]  esc_char;
   logic [15:0] acc_next;
   logic        bad_next;
   logic        last_digit;
   logic [10:0] plane;
   utf8_type    enc_bmp, enc_pair;
   logic        fail_en;
   logic [3:0]  fail_code;
   logic        accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      hv         = hex_value(in_byte);
      ev         = escape_map(in_byte, esc_char);
      acc_next   = {acc_ff[11:0], hv.val};
      bad_next   = bad_ff | !hv.ok;
      last_digit = (cnt_ff == 2'd3);
      plane      = {1'b0, hi_ff} + 11'd64;
      enc_bmp    = utf8_encode({5'd0, acc_next});
      enc_pair   = utf8_encode({plane, acc_next[9:0]});
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      hi_in     = hi_ff;
      cnt_in    = cnt_ff;
      bad_in    = bad_ff;
      burst     = '0;
      fail_en   = 1'b0;
      fail_code = ERR_UNEXPECTED;
      case (phase_ff)
         PH_IDLE: begin
            if (in_byte == CH_QUOTE) begin
               phase_in = PH_STR;
               if (in_last) begin
                  fail_en   = 1'b1;
                  fail_code = ERR_UNTERMINATED;
               end
            end else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                         in_byte == CH_LF || in_byte == CH_CR) begin
               fail_en   = in_last;
               fail_code = ERR_UNEXPECTED;
            end else begin
               fail_en   = 1'b1;
               fail_code = ERR_UNEXPECTED;
            end
         end
         PH_STR: begin
            if (in_byte == CH_QUOTE) begin
               burst.tail_en   = 1'b1;
               burst.tail_kind = KIND_DONE;
               phase_in        = PH_IDLE;
            end else if (in_byte == CH_BACKSLASH) begin
               phase_in  = PH_ESC;
               fail_en   = in_last;
               fail_code = ERR_CUT_ESCAPE;
            end else if (in_byte < CH_SPACE) begin
               fail_en   = 1'b1;
               fail_code = ERR_RAW_CONTROL;
            end else begin
               burst.nbytes = 3'd1;
               burst.data   = {24'd0, in_byte};
               fail_en      = in_last;
               fail_code    = ERR_UNTERMINATED;
            end
         end
         PH_ESC: begin
            if (ev.ok) begin
               burst.nbytes = 3'd1;
               burst.data   = {24'd0, esc_char};
               phase_in     = PH_STR;
               fail_en      = in_last;
               fail_code    = ERR_UNTERMINATED;
            end else if (in_byte == CH_U) begin
               acc_in    = '0;
               cnt_in    = '0;
               bad_in    = 1'b0;
               phase_in  = PH_HEX;
               fail_en   = in_last;
               fail_code = ERR_SHORT_HEX;
            end else begin
               fail_en   = 1'b1;
               fail_code = ERR_BAD_ESCAPE;
            end
         end
         PH_HEX: begin
            acc_in = acc_next;
            bad_in = bad_next;
            cnt_in = cnt_ff + 2'd1;
            if (last_digit) begin
               if (bad_next) begin
                  fail_en   = 1'b1;
                  fail_code = ERR_BAD_HEX;
               end else if (acc_next[15:10] == SURR_HIGH) begin
                  hi_in     = acc_next[9:0];
                  phase_in  = PH_WANT_BS;
                  fail_en   = in_last;
                  fail_code = ERR_NO_LOW;
               end else if (acc_next[15:10] == SURR_LOW) begin
                  fail_en   = 1'b1;
                  fail_code = ERR_STRAY_LOW;
               end else begin
                  burst.nbytes = enc_bmp.nbytes;
                  burst.data   = enc_bmp.data;
                  phase_in     = PH_STR;
                  fail_en      = in_last;
                  fail_code    = ERR_UNTERMINATED;
               end
            end else begin
               fail_en   = in_last;
               fail_code = ERR_SHORT_HEX;
            end
         end
         PH_WANT_BS: begin
            if (in_byte == CH_BACKSLASH) begin
               phase_in = PH_WANT_U;
               fail_en  = in_last;
            end else begin
               fail_en  = 1'b1;
            end
            fail_code = ERR_NO_LOW;
         end
         PH_WANT_U: begin
            if (in_byte == CH_U) begin
               acc_in    = '0;
               cnt_in    = '0;
               bad_in    = 1'b0;
               phase_in  = PH_LOW_HEX;
               fail_en   = in_last;
               fail_code = ERR_BAD_LOW;
            end else begin
               fail_en   = 1'b1;
               fail_code = ERR_NO_LOW;
            end
         end
         PH_LOW_HEX: begin
            acc_in    = acc_next;
            bad_in    = bad_next;
            cnt_in    = cnt_ff + 2'd1;
            fail_code = ERR_BAD_LOW;
            if (last_digit) begin
               if (bad_next || acc_next[15:10] != SURR_LOW) begin
                  fail_en = 1'b1;
               end else begin
                  burst.nbytes = enc_pair.nbytes;
                  burst.data   = enc_pair.data;
                  phase_in     = PH_STR;
                  fail_en      = in_last;
                  fail_code    = ERR_UNTERMINATED;
               end
            end else begin
               fail_en = in_last;
            end
         end
         default: begin
            // error recovery: swallow bytes until end of text
         end
      endcase
      if (fail_en) begin
         burst.tail_en   = 1'b1;
         burst.tail_kind = KIND_ERROR;
         burst.tail_code = fail_code;
         phase_in        = PH_DEAD;
      end
      if (in_last) begin
         phase_in = PH_IDLE;
      end
   end

   assign push = accept && (burst.nbytes != 3'd0 || burst.tail_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         hi_ff    <= '0;
         cnt_ff   <= '0;
         bad_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         hi_ff    <= hi_in;
         cnt_ff   <= cnt_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

FILE: hw/rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// short fifo of result bursts between the scanner and the output sequencer
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type push_burst,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output burst_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   burst_type         slot_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// output sequencer: unrolls one burst into result words; unless the output stalls, one per cycle
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       burst_valid,
   input  burst_type  burst,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [1:0] out_kind,
   output logic [7:0] out_byte,
   output logic [3:0] out_code,
   output logic       out_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] code_ff, code_in;
   logic       last_ff, last_in;
   logic       load;
   logic       in_bytes;
   logic       final_word;

   assign load       = burst_valid && (!valid_ff || out_ready);
   assign in_bytes   = (idx_ff < burst.nbytes);
   assign final_word = in_bytes ? (idx_ff == burst.nbytes - 3'd1) && !burst.tail_en : 1'b1;
   assign pop        = load && final_word;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_ready;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      code_in  = code_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = final_word;
         idx_in   = final_word ? 3'd0 : idx_ff + 3'd1;
         if (in_bytes) begin
            kind_in = KIND_BYTE;
            byte_in = burst.data[{idx_ff[1:0], 3'b000} +: 8];
            code_in = 4'd0;
         end else begin
            kind_in = burst.tail_kind;
            byte_in = 8'd0;
            code_in = burst.tail_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_code  = code_ff;
   assign out_last  = last_ff;

endmodule

FILE: hw/rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// unescapes a json string from a byte stream into utf-8 content words
// ----------------------------------------------------------------------------
// Text bytes enter on the req_ stream, one byte per word, with req_tlast
// marking the last byte of the text. Leading json whitespace is skipped, an
// opening quote starts the string, and every content byte, simple escape and
// \uXXXX escape (surrogate pairs joined) comes out as utf-8 bytes on the rsp_
// stream, followed by a completion word at the closing quote. Any error gives
// a single error word and the rest of the text up to req_tlast is dropped.
// rsp_tlast flags the last result word caused by an input byte. The scanner
// takes one byte per cycle while its burst queue (QUEUE_DEPTH entries) has
// room; the output sequencer sends one result word per cycle while the output
// is not stalled, so a byte that yields n results holds the output side until
// all n are sent (n from 0 to 5, four utf-8 bytes plus an error word at most).
// With rsp_tready high, plain text sustains one input byte per cycle, and
// the scanner waits on a full queue while multi-byte code points are written
// out. Each result word passes the burst queue, then the output register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // text stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] text_byte
   input  logic                  req_tlast,   // end_of_text
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] content_byte, [11:8] error_code,
                                              // [15:12] zero
   output logic [1:0]            rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast    // run_end
);

   // burst handoff between scanner and sequencer
   logic      push;
   burst_type push_burst;
   logic      queue_full;
   logic      pop;
   logic      burst_valid;
   burst_type head_burst;

   // output word fields
   logic [7:0] out_byte;
   logic [3:0] out_code;

   // scanner: phase machine, hex accumulator and utf-8 encoder
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata[7:0]),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .burst      (push_burst)
   );

   // bursts wait here so the scanner keeps going while the output stalls
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (burst_valid),
      .head       (head_burst)
   );

   // sequencer: one result word per cycle into the output register while the output is not stalled
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (head_burst),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_byte    (out_byte),
      .out_code    (out_code),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, out_code, out_byte};

endmodule

FILE: hw/rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks on the result stream of the json string unescaper
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed under stall");

   // completion and error words always close the run of their byte
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tlast)
      else $error("completion or error word without run end");

   // only the three defined kinds appear
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == KIND_BYTE || rsp_tuser == KIND_DONE ||
                     rsp_tuser == KIND_ERROR)
      else $error("undefined result kind");

   // content words carry no code, error words no byte and a defined code
   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'd0 &&
                     (rsp_tuser == KIND_BYTE || rsp_tdata[7:0] == 8'd0) &&
                     (rsp_tuser == KIND_ERROR || rsp_tdata[11:8] == 4'd0) &&
                     rsp_tdata[11:8] <= ERR_UNTERMINATED)
      else $error("stray bits in result word");

   // after an error word is taken, a next error word must also close its run
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_ERROR |=>
         !rsp_tvalid || rsp_tuser != KIND_ERROR || rsp_tlast)
      else $error("error word not closing its run");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
